[rtl/scw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_pkg
// shared types and constants of the scaled, rotated clip window block
// ----------------------------------------------------------------------------
package scw_pkg;

    localparam int COORD_W    = 12;                 // coordinate and register width
    localparam int OUT_W      = COORD_W + 1;        // panel and source offset width
    localparam int SCALE_SH   = 8;                  // log2 of the scale denominator
    localparam int SPAN_W     = 16;                 // scaled image length width
    localparam int PROD_W     = 2 * COORD_W;        // 12x12 product width
    localparam int DIVD_W     = 26;                 // dividend and quotient width
    localparam int DIV_STEPS  = 2;                  // quotient bits per divider stage
    localparam int DIV_STAGES = DIVD_W / DIV_STEPS;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam logic [COORD_W-1:0] SCALE_NUM_RST = 12'd256;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_CROP_X       = 3'd2,
        REG_CROP_Y       = 3'd3,
        REG_SCALE_NUM    = 3'd4,
        REG_ROTATION     = 3'd5,
        REG_TARGET_X     = 3'd6,
        REG_TARGET_Y     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] image_width;
        logic [COORD_W-1:0] image_height;
        logic [COORD_W-1:0] crop_x;
        logic [COORD_W-1:0] crop_y;
        logic [COORD_W-1:0] scale_num;
        logic [1:0]         rotation;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } cfg_t;

    // per-axis info that rides along with the divider
    typedef struct packed {
        logic              fail;
        logic [SPAN_W-1:0] scaled;
    } axis_tag_t;

    // one long-division lane
    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [DIVD_W-1:0]  num;
        logic [DIVD_W-1:0]  quo;
    } div_st_t;

    typedef struct packed {
        logic               ok;
        logic [OUT_W-1:0]   first;
        logic [COORD_W-1:0] count;
        logic [OUT_W-1:0]   off;
    } axis_res_t;

endpackage

[rtl/scw_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_cfg
// register file behind the apb-style configuration port
// ----------------------------------------------------------------------------
module scw_cfg import scw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg           <= '0;
            cfg_reg.scale_num <= SCALE_NUM_RST;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[COORD_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[COORD_W-1:0];
                REG_CROP_X:       cfg_reg.crop_x       <= pwdata[COORD_W-1:0];
                REG_CROP_Y:       cfg_reg.crop_y       <= pwdata[COORD_W-1:0];
                REG_SCALE_NUM:    cfg_reg.scale_num    <= pwdata[COORD_W-1:0];
                REG_ROTATION:     cfg_reg.rotation     <= pwdata[1:0];
                REG_TARGET_X:     cfg_reg.target_x     <= pwdata[COORD_W-1:0];
                REG_TARGET_Y:     cfg_reg.target_y     <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_reg.image_height);
            REG_CROP_X:       prdata = DATA_W'(cfg_reg.crop_x);
            REG_CROP_Y:       prdata = DATA_W'(cfg_reg.crop_y);
            REG_SCALE_NUM:    prdata = DATA_W'(cfg_reg.scale_num);
            REG_ROTATION:     prdata = DATA_W'(cfg_reg.rotation);
            REG_TARGET_X:     prdata = DATA_W'(cfg_reg.target_x);
            REG_TARGET_Y:     prdata = DATA_W'(cfg_reg.target_y);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/scw_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_div
// pipelined restoring divider, two quotients over one divisor
// ----------------------------------------------------------------------------
module scw_div import scw_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [COORD_W-1:0] divisor,
    input  logic [DIVD_W-1:0]  num_a,
    input  logic [DIVD_W-1:0]  num_b,
    input  axis_tag_t          tag_in,
    output logic [DIVD_W-1:0]  quo_a,
    output logic [DIVD_W-1:0]  quo_b,
    output axis_tag_t          tag_out
);

    div_st_t   a_reg   [DIV_STAGES+1];
    div_st_t   b_reg   [DIV_STAGES+1];
    axis_tag_t tag_reg [DIV_STAGES+1];
    div_st_t   a_next  [DIV_STAGES];
    div_st_t   b_next  [DIV_STAGES];

    function automatic div_st_t div_step(div_st_t s, logic [COORD_W-1:0] d);
        logic [COORD_W:0] t;
        div_st_t          r;
        t     = {s.rem, s.num[DIVD_W-1]};
        r.num = {s.num[DIVD_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = COORD_W'(t - {1'b0, d});
            r.quo = {s.quo[DIVD_W-2:0], 1'b1};
        end else begin
            r.rem = t[COORD_W-1:0];
            r.quo = {s.quo[DIVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            a_next[s] = a_reg[s];
            b_next[s] = b_reg[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                a_next[s] = div_step(a_next[s], divisor);
                b_next[s] = div_step(b_next[s], divisor);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0]   <= '{rem: '0, num: num_a, quo: '0};
            b_reg[0]   <= '{rem: '0, num: num_b, quo: '0};
            tag_reg[0] <= tag_in;
            for (int s = 0; s < DIV_STAGES; s++) begin
                a_reg[s+1]   <= a_next[s];
                b_reg[s+1]   <= b_next[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign quo_a   = a_reg[DIV_STAGES].quo;
    assign quo_b   = b_reg[DIV_STAGES].quo;
    assign tag_out = tag_reg[DIV_STAGES];

endmodule

[rtl/scw_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_axis
// per-axis clamp, even alignment, rescale and placement, three stages
// ----------------------------------------------------------------------------
module scw_axis import scw_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [DIVD_W-1:0]  quo_a,
    input  logic [DIVD_W-1:0]  quo_b,
    input  axis_tag_t          tag,
    input  logic [COORD_W-1:0] base,
    input  logic [COORD_W-1:0] len,
    input  logic [COORD_W-1:0] n,
    input  logic               rev,
    output axis_res_t          res
);

    // stage 1: clamp and align
    logic [COORD_W-1:0]  b_c, b1;
    logic [DIVD_W:0]     a1;
    logic                par_b, fail1;

    logic                p1_fail_reg;
    logic [COORD_W-1:0]  p1_a_reg, p1_cnt_reg;
    logic [OUT_W-1:0]    p1_first_reg;
    logic [SPAN_W-1:0]   p1_scaled_reg;

    // stage 2: rescale start and count
    logic [PROD_W-1:0]   start_prod, outn_prod;
    logic                p2_fail_reg;
    logic [COORD_W-1:0]  p2_cnt_reg;
    logic [OUT_W-1:0]    p2_first_reg;
    logic [SPAN_W-1:0]   p2_scaled_reg, p2_start_reg, p2_outn_reg;

    // stage 3: offset on the scaled axis
    axis_res_t           res_reg;
    axis_res_t           res_next;

    always_comb begin
        b_c   = (quo_b > DIVD_W'(len)) ? len : quo_b[COORD_W-1:0];
        a1    = {1'b0, quo_a} + (DIVD_W+1)'(base[0] ^ quo_a[0]);
        par_b = base[0] ^ b_c[0];
        b1    = b_c - COORD_W'(par_b);
        fail1 = tag.fail || (par_b && (b_c == '0)) || ((DIVD_W+1)'(b1) <= a1);
    end

    assign start_prod = p1_a_reg * n;
    assign outn_prod  = p1_cnt_reg * n;

    always_comb begin
        res_next.ok    = !p2_fail_reg && (p2_outn_reg != '0);
        res_next.first = p2_first_reg;
        res_next.count = p2_cnt_reg;
        res_next.off   = rev ? OUT_W'(p2_scaled_reg - p2_start_reg - p2_outn_reg)
                             : p2_start_reg[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_fail_reg   <= fail1;
            p1_a_reg      <= a1[COORD_W-1:0];
            p1_cnt_reg    <= b1 - a1[COORD_W-1:0];
            p1_first_reg  <= {1'b0, base} + {1'b0, a1[COORD_W-1:0]};
            p1_scaled_reg <= tag.scaled;

            p2_fail_reg   <= p1_fail_reg;
            p2_cnt_reg    <= p1_cnt_reg;
            p2_first_reg  <= p1_first_reg;
            p2_scaled_reg <= p1_scaled_reg;
            p2_start_reg  <= start_prod[SCALE_SH +: SPAN_W];
            p2_outn_reg   <= outn_prod[SCALE_SH +: SPAN_W];

            res_reg       <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/scaled_rotated_clip_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_rotated_clip_window
// clip a panel rectangle against a scaled, rotated and cropped source image
// ----------------------------------------------------------------------------
// Each input item is a visible panel rectangle; each output item says whether
// a source block must be scaled, which even-aligned source block it is, and
// where on the panel it lands. One item is accepted per clock while the skid
// entry is empty, and one result comes out per item, in order. The 13-stage
// divider (two quotient bits per stage) turns panel spans into source spans
// for each axis. An output register plus a skid entry sit at the end, so input
// keeps flowing while one result waits; it stalls once the skid entry is full.
// Configuration must be written only while no item is in flight.
// ----------------------------------------------------------------------------
module scaled_rotated_clip_window import scw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // vis_x[11:0], vis_y[23:12], vis_w[35:24], vis_h[47:36]
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // src_x[12:0], src_w[24:13], src_y[37:25],
                                         // src_h[49:38], dst_x[62:50], dst_y[75:63], zero pad
    output logic              m_tuser    // draw_needed
);

    localparam int SIDE_LEN = DIV_STAGES + 5;   // stage 0 through the placement stage

    typedef struct packed {
        logic              fail;
        logic [DIVD_W-1:0] num_a;
        logic [DIVD_W-1:0] num_b;
    } prep_t;

    cfg_t cfg;

    // pipeline advances unless the skid entry is occupied
    logic en;

    // stage 0 registers
    logic [OUT_W-1:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [PROD_W-1:0] prod_w_reg, prod_h_reg;

    // valid and early-reject flags travel alongside the payload
    logic              valid_reg [SIDE_LEN];
    logic              early_reg [SIDE_LEN];

    // input fields
    logic [COORD_W-1:0] vis_x, vis_y, vis_w, vis_h;
    logic               early;

    // stage 1 axis preparation
    logic [SPAN_W-1:0]   sw, sh;
    logic                swap, urev, vrev;
    prep_t               u_prep, v_prep;

    // divider and axis outputs
    logic [DIVD_W-1:0] u_qa, u_qb, v_qa, v_qb;
    axis_tag_t         u_tag, v_tag;
    axis_res_t         u_res, v_res;

    // final stage, output register and skid entry
    logic              fin_valid_reg, ok;
    logic [79:0]       fin_data_reg, fin_data_next;
    logic              fin_user_reg;
    logic [OUT_W-1:0]  dst_x, dst_y;
    logic              out_valid_reg, skid_valid_reg;
    logic [79:0]       out_data_reg, skid_data_reg;
    logic              out_user_reg, skid_user_reg;
    logic              fire, out_free;

    scw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign vis_x = s_tdata[11:0];
    assign vis_y = s_tdata[23:12];
    assign vis_w = s_tdata[35:24];
    assign vis_h = s_tdata[47:36];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // nothing to draw: zero width, zero scale, or rectangle before target
    assign early = (vis_w == '0) || (cfg.scale_num == '0) ||
                   (vis_x < cfg.target_x) || (vis_y < cfg.target_y);

    // stage 0: panel offsets and scaled image products
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg     <= {1'b0, COORD_W'(vis_x - cfg.target_x)};
            y0_reg     <= {1'b0, COORD_W'(vis_y - cfg.target_y)};
            x1_reg     <= {1'b0, COORD_W'(vis_x - cfg.target_x)} + {1'b0, vis_w};
            y1_reg     <= {1'b0, COORD_W'(vis_y - cfg.target_y)} + {1'b0, vis_h};
            prod_w_reg <= cfg.image_width * cfg.scale_num;
            prod_h_reg <= cfg.image_height * cfg.scale_num;
        end
    end

    // control: valid and early flag shift along the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_LEN; i++) begin
                valid_reg[i] <= 1'b0;
                early_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            early_reg[0] <= early;
            for (int i = 1; i < SIDE_LEN; i++) begin
                valid_reg[i] <= valid_reg[i-1];
                early_reg[i] <= early_reg[i-1];
            end
        end
    end

    // stage 1: mirror reversed axes, form ceiling and floor dividends
    function automatic prep_t axis_prep(logic [OUT_W-1:0] lo, logic [OUT_W-1:0] hi,
                                        logic [SPAN_W-1:0] scaled, logic rev,
                                        logic [COORD_W-1:0] n);
        logic [SPAN_W-1:0]   lo_e, hi_e;
        prep_t               r;
        lo_e   = SPAN_W'(lo);
        hi_e   = SPAN_W'(hi);
        r.fail = 1'b0;
        if (rev) begin
            // a mirrored span past the scaled length is empty
            r.fail = (hi_e > scaled) || (lo_e > scaled);
            lo_e   = scaled - SPAN_W'(hi);
            hi_e   = scaled - SPAN_W'(lo);
        end
        r.num_a = (DIVD_W'(lo_e) << SCALE_SH) + DIVD_W'(n) - DIVD_W'(1);
        r.num_b = DIVD_W'(hi_e) << SCALE_SH;
        return r;
    endfunction

    assign sw   = prod_w_reg[SCALE_SH +: SPAN_W];
    assign sh   = prod_h_reg[SCALE_SH +: SPAN_W];
    // 90 and 270 swap the axes; 90 and 180 mirror u; 180 and 270 mirror v
    assign swap = (cfg.rotation == 2'd1) || (cfg.rotation == 2'd3);
    assign urev = (cfg.rotation == 2'd1) || (cfg.rotation == 2'd2);
    assign vrev = (cfg.rotation == 2'd2) || (cfg.rotation == 2'd3);

    assign u_prep = axis_prep(swap ? y0_reg : x0_reg, swap ? y1_reg : x1_reg,
                              sw, urev, cfg.scale_num);
    assign v_prep = axis_prep(swap ? x0_reg : y0_reg, swap ? x1_reg : y1_reg,
                              sh, vrev, cfg.scale_num);

    scw_div u_div_u (
        .aclk    (aclk),
        .en      (en),
        .divisor (cfg.scale_num),
        .num_a   (u_prep.num_a),
        .num_b   (u_prep.num_b),
        .tag_in  ('{fail: u_prep.fail, scaled: sw}),
        .quo_a   (u_qa),
        .quo_b   (u_qb),
        .tag_out (u_tag)
    );

    scw_div u_div_v (
        .aclk    (aclk),
        .en      (en),
        .divisor (cfg.scale_num),
        .num_a   (v_prep.num_a),
        .num_b   (v_prep.num_b),
        .tag_in  ('{fail: v_prep.fail, scaled: sh}),
        .quo_a   (v_qa),
        .quo_b   (v_qb),
        .tag_out (v_tag)
    );

    scw_axis u_axis_u (
        .aclk  (aclk),
        .en    (en),
        .quo_a (u_qa),
        .quo_b (u_qb),
        .tag   (u_tag),
        .base  (cfg.crop_x),
        .len   (cfg.image_width),
        .n     (cfg.scale_num),
        .rev   (urev),
        .res   (u_res)
    );

    scw_axis u_axis_v (
        .aclk  (aclk),
        .en    (en),
        .quo_a (v_qa),
        .quo_b (v_qb),
        .tag   (v_tag),
        .base  (cfg.crop_y),
        .len   (cfg.image_height),
        .n     (cfg.scale_num),
        .rev   (vrev),
        .res   (v_res)
    );

    // final stage: place the block on the panel, zero everything if empty
    assign ok    = !early_reg[SIDE_LEN-1] && u_res.ok && v_res.ok;
    assign dst_x = {1'b0, cfg.target_x} + (swap ? v_res.off : u_res.off);
    assign dst_y = {1'b0, cfg.target_y} + (swap ? u_res.off : v_res.off);

    always_comb begin
        fin_data_next = '0;
        if (ok) begin
            fin_data_next[12:0]  = u_res.first;
            fin_data_next[24:13] = u_res.count;
            fin_data_next[37:25] = v_res.first;
            fin_data_next[49:38] = v_res.count;
            fin_data_next[62:50] = dst_x;
            fin_data_next[75:63] = dst_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= fin_data_next;
            fin_user_reg <= ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= valid_reg[SIDE_LEN-1];
        end
    end

    // output register with one skid entry behind it
    assign fire     = en && fin_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= fire;
            end
        end else if (fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else if (fire) begin
                out_data_reg <= fin_data_reg;
                out_user_reg <= fin_user_reg;
            end
        end else if (fire) begin
            skid_data_reg <= fin_data_reg;
            skid_user_reg <= fin_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scaled, rotated clip window block
// ----------------------------------------------------------------------------
// Rectangles are streamed in under several register settings. A local clip
// model predicts each result item, which is compared field by field with
// what the block returns, in order. The sender works in bursts, the receiver
// stalls on its own pattern, and once it holds off long enough to back up
// the whole pipeline.
// ----------------------------------------------------------------------------
module tb;
    import scw_pkg::*;

    localparam int PIPE_LAT   = 20;
    localparam int CYCLE_MAX  = 400000;

    // result item as the block packs it
    typedef struct {
        logic        draw;
        logic [12:0] src_x;
        logic [11:0] src_w;
        logic [12:0] src_y;
        logic [11:0] src_h;
        logic [12:0] dst_x;
        logic [12:0] dst_y;
    } clip_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // vis_x, vis_y, vis_w, vis_h from bit 0 up
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [79:0]       m_tdata;        // src_x, src_w, src_y, src_h, dst_x, dst_y
    logic              m_tuser;        // draw_needed

    // model copy of the registers
    int unsigned img_w, img_h, crop_l, crop_t, scale_n, rot, tgt_x, tgt_y;

    clip_res_t   pending_clips[$];
    int          err_count = 0;
    int          sent_count = 0;
    int          got_count = 0;
    int          drawn_count = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;   // receiver hold-off request

    scaled_rotated_clip_window dut (.*);

    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch item %0d %s: got %0d expected %0d", got_count, what, got, exp);
        err_count++;
    endtask

    // one source axis: returns ok, fills first source position, count and offset
    function automatic bit clip_one_axis(input longint base, len, scaled, n, lo_in, hi_in,
                                         input bit rev, output longint first,
                                         output longint count, output longint off);
        longint lo, hi, a, b, st, outn;
        lo = lo_in;
        hi = hi_in;
        first = 0; count = 0; off = 0;
        if (rev) begin
            if (hi > scaled || lo > scaled) return 0;
            lo = scaled - hi_in;
            hi = scaled - lo_in;
        end
        a = (lo * 256 + n - 1) / n;
        b = hi * 256 / n;
        if (b > len) b = len;
        if ((base + a) % 2 != 0) a++;
        if ((base + b) % 2 != 0) begin
            if (b == 0) return 0;
            b--;
        end
        if (b <= a) return 0;
        st = a * n / 256;
        outn = (b - a) * n / 256;
        if (outn == 0) return 0;
        first = base + a;
        count = b - a;
        off = rev ? scaled - st - outn : st;
        return 1;
    endfunction

    function automatic clip_res_t predict_clip(input logic [47:0] rect);
        clip_res_t r;
        longint vx, vy, vw, vh, sw, sh, x0, y0, x1, y1;
        longint uf, uc, uo, vf, vc, vo;
        bit swp, urev, vrev, ok;
        vx = rect[11:0]; vy = rect[23:12]; vw = rect[35:24]; vh = rect[47:36];
        r = '{default: 0};
        if (vw == 0 || scale_n == 0) return r;
        if (vx < tgt_x || vy < tgt_y) return r;
        sw = longint'(img_w) * scale_n / 256;
        sh = longint'(img_h) * scale_n / 256;
        x0 = vx - tgt_x; y0 = vy - tgt_y;
        x1 = x0 + vw;    y1 = y0 + vh;
        swp  = (rot == 1 || rot == 3);
        urev = (rot == 1 || rot == 2);
        vrev = (rot == 2 || rot == 3);
        ok = clip_one_axis(crop_l, img_w, sw, scale_n, swp ? y0 : x0, swp ? y1 : x1,
                           urev, uf, uc, uo);
        if (ok)
            ok = clip_one_axis(crop_t, img_h, sh, scale_n, swp ? x0 : y0, swp ? x1 : y1,
                               vrev, vf, vc, vo);
        if (!ok) return r;
        r.draw  = 1'b1;
        r.src_x = 13'(uf);
        r.src_w = 12'(uc);
        r.src_y = 13'(vf);
        r.src_h = 12'(vc);
        r.dst_x = 13'(tgt_x + (swp ? vo : uo));
        r.dst_y = 13'(tgt_y + (swp ? uo : vo));
        return r;
    endfunction

    // receiver: own stall pattern plus the long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            clip_res_t e;
            if (pending_clips.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                e = pending_clips.pop_front();
                if (m_tuser !== e.draw) report_mismatch("draw_needed", m_tuser, e.draw);
                if (m_tdata[12:0] !== e.src_x) report_mismatch("src_x", m_tdata[12:0], e.src_x);
                if (m_tdata[24:13] !== e.src_w) report_mismatch("src_w", m_tdata[24:13], e.src_w);
                if (m_tdata[37:25] !== e.src_y) report_mismatch("src_y", m_tdata[37:25], e.src_y);
                if (m_tdata[49:38] !== e.src_h) report_mismatch("src_h", m_tdata[49:38], e.src_h);
                if (m_tdata[62:50] !== e.dst_x) report_mismatch("dst_x", m_tdata[62:50], e.dst_x);
                if (m_tdata[75:63] !== e.dst_y) report_mismatch("dst_y", m_tdata[75:63], e.dst_y);
                if (m_tdata[79:76] !== 4'd0) report_mismatch("pad", m_tdata[79:76], 0);
                if (e.draw) drawn_count++;
            end
            got_count++;
        end
    end

    // one item, burst style, with a random gap in front of some bursts
    int burst_left = 0;
    task automatic send_rect(input logic [11:0] vx, vy, vw, vh);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {vh, vw, vy, vx};
        pending_clips.push_back(predict_clip({vh, vw, vy, vx}));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  img_w   = val & 12'hFFF;
            REG_IMAGE_HEIGHT: img_h   = val & 12'hFFF;
            REG_CROP_X:       crop_l  = val & 12'hFFF;
            REG_CROP_Y:       crop_t  = val & 12'hFFF;
            REG_SCALE_NUM:    scale_n = val & 12'hFFF;
            REG_ROTATION:     rot     = val & 2'h3;
            REG_TARGET_X:     tgt_x   = val & 12'hFFF;
            default:          tgt_y   = val & 12'hFFF;
        endcase
    endtask

    task automatic apply_setting(input int unsigned w, h, cl, ct, sn, r, tx, ty);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CROP_X, cl);
        write_reg(REG_CROP_Y, ct);
        write_reg(REG_SCALE_NUM, sn);
        write_reg(REG_ROTATION, r);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
    endtask

    // rectangle mostly inside the scaled image, sometimes anything at all
    task automatic send_random_rect();
        int unsigned sw, sh, pw, ph;
        if ($urandom_range(0, 4) == 0) begin
            send_rect(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        end else begin
            sw = img_w * scale_n / 256;
            sh = img_h * scale_n / 256;
            pw = (rot % 2) ? sh : sw;
            ph = (rot % 2) ? sw : sh;
            if (pw > 4095) pw = 4095;
            if (ph > 4095) ph = 4095;
            send_rect(12'(tgt_x + $urandom_range(0, pw)), 12'(tgt_y + $urandom_range(0, ph)),
                      12'($urandom_range(0, pw + 8)), 12'($urandom_range(0, ph + 8)));
        end
    endtask

    // reset defaults, zero width, rectangle before target, extremes
    task automatic test_directed();
        send_rect(0, 0, 0, 0);
        send_rect(0, 0, 100, 100);
        apply_setting(640, 480, 3, 5, 256, 0, 100, 50);
        send_rect(100, 50, 0, 40);
        send_rect(99, 50, 20, 20);
        send_rect(100, 49, 20, 20);
        send_rect(100, 50, 640, 480);
        send_rect(101, 51, 1, 1);
        send_rect(4095, 4095, 4095, 4095);
        send_rect(700, 500, 4095, 4095);
        for (int r = 0; r < 4; r++) begin
            apply_setting(4095, 4095, 4095, 4095, 4095, r, 4095, 4095);
            send_rect(4095, 4095, 4095, 4095);
            send_rect(4095, 4095, 1, 1);
            apply_setting(321, 199, 1, 0, 1 + r * 300, r, 7, 9);
            send_rect(7, 9, 4095, 4095);
            send_rect(20, 30, 50, 3);
        end
        apply_setting(100, 100, 0, 0, 0, 0, 0, 0);
        send_rect(0, 0, 50, 50);
        send_rect(10, 10, 4095, 0);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
                                                      : $urandom_range(64, 1024),
                          $urandom_range(0, 3), $urandom_range(0, 600),
                          $urandom_range(0, 600));
            repeat (per_phase) send_random_rect();
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        apply_setting(800, 600, 2, 2, 300, 1, 10, 10);
        hold_cycles = 200;
        repeat (80) send_random_rect();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        img_w = 0; img_h = 0; crop_l = 0; crop_t = 0;
        scale_n = SCALE_NUM_RST; rot = 0; tgt_x = 0; tgt_y = 0;
        test_directed();
        test_backpressure();
        test_random_settings(12, 62);
        wait_idle();
        $display("%0d items sent, %0d results checked, %0d of them drawn",
                 sent_count, got_count, drawn_count);
        $display("all rotations, scale extremes and receiver hold-off exercised");
        if (err_count == 0 && pending_clips.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
rtl/scw_pkg.sv
rtl/scw_cfg.sv
rtl/scw_div.sv
rtl/scw_axis.sv
rtl/scaled_rotated_clip_window.sv
tb/tb.sv
